/* hdl/dq_pkg.sv */
// Shared widths, command codes and status codes for the double-ended queue.
`timescale 1ns / 1ps
package dq_pkg;

    localparam int DATA_W        = 64;
    localparam int CMD_W         = 3;
    localparam int ENTRY_W       = 9;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 256;

    localparam int S_FIELDS_W = CMD_W + DATA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 * DATA_W + ENTRY_W + STATUS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_REVERSE    = 3'd4,
        CMD_QUERY      = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

/* hdl/dq_ring_mem.sv */
// Ring store: one write port and one registered read port.
`timescale 1ns / 1ps
module dq_ring_mem #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [dq_pkg::DATA_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [dq_pkg::DATA_W-1:0] rd_data
);
    import dq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/dq_ctrl.sv */
// Pointer, direction and end-value control with the result register.
`timescale 1ns / 1ps
module dq_ctrl #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  dq_pkg::cmd_t                s_cmd,
    input  logic [dq_pkg::DATA_W-1:0]   s_value,
    output logic                        mem_wr_en,
    output logic [AW-1:0]               mem_wr_addr,
    output logic [dq_pkg::DATA_W-1:0]   mem_wr_data,
    output logic                        mem_rd_en,
    output logic [AW-1:0]               mem_rd_addr,
    input  logic [dq_pkg::DATA_W-1:0]   mem_rd_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [dq_pkg::DATA_W-1:0]   m_front,
    output logic [dq_pkg::DATA_W-1:0]   m_back,
    output logic [dq_pkg::ENTRY_W-1:0]  m_count,
    output dq_pkg::status_t             m_status
);
    import dq_pkg::*;

    localparam int SW = AW + 1;

    typedef enum logic {S_IDLE, S_RESULT} state_t;

    state_t               state_reg,      state_next;
    logic [AW-1:0]        head_reg,       head_next;
    logic [CW-1:0]        count_reg,      count_next;
    logic                 rev_reg,        rev_next;
    logic [DATA_W-1:0]    first_reg,      first_next;
    logic [DATA_W-1:0]    last_reg,       last_next;
    status_t              status_reg,     status_next;
    logic                 load_first_reg, load_first_next;
    logic                 load_last_reg,  load_last_next;
    logic                 out_valid_reg,  out_valid_next;
    logic [DATA_W-1:0]    front_out_reg,  front_out_next;
    logic [DATA_W-1:0]    back_out_reg,   back_out_next;
    logic [ENTRY_W-1:0]   count_out_reg,  count_out_next;
    status_t              stat_out_reg,   stat_out_next;

    logic                 is_full;
    logic                 is_empty;
    logic [AW-1:0]        head_inc;
    logic [AW-1:0]        head_dec;
    logic [CW-1:0]        offset;
    logic [SW-1:0]        slot_sum;
    logic [AW-1:0]        slot;
    logic [DATA_W-1:0]    first_eff;
    logic [DATA_W-1:0]    last_eff;
    logic                 out_free;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);

    assign offset   = (s_cmd == CMD_PUSH_FRONT || s_cmd == CMD_PUSH_BACK)
                      ? count_reg : count_reg - CW'(2);
    assign slot_sum = SW'(head_reg) + SW'(offset);
    assign slot     = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH))
                                                : AW'(slot_sum);

    assign first_eff = load_first_reg ? mem_rd_data : first_reg;
    assign last_eff  = load_last_reg  ? mem_rd_data : last_reg;
    assign out_free  = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        rev_next        = rev_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        status_next     = status_reg;
        load_first_next = load_first_reg;
        load_last_next  = load_last_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        front_out_next  = front_out_reg;
        back_out_next   = back_out_reg;
        count_out_next  = count_out_reg;
        stat_out_next   = stat_out_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = slot;
        mem_wr_data     = s_value;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = slot;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next      = S_RESULT;
                    status_next     = ST_OK;
                    load_first_next = 1'b0;
                    load_last_next  = 1'b0;
                    case (s_cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else if ((s_cmd == CMD_PUSH_FRONT) != rev_reg) begin
                                head_next   = head_dec;
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = head_dec;
                                first_next  = s_value;
                                if (is_empty) begin
                                    last_next = s_value;
                                end
                                count_next  = count_reg + CW'(1);
                            end else begin
                                mem_wr_en  = 1'b1;
                                last_next  = s_value;
                                if (is_empty) begin
                                    first_next = s_value;
                                end
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else if ((s_cmd == CMD_POP_FRONT) != rev_reg) begin
                                head_next       = head_inc;
                                count_next      = count_reg - CW'(1);
                                mem_rd_en       = 1'b1;
                                mem_rd_addr     = head_inc;
                                load_first_next = (count_reg != CW'(1));
                            end else begin
                                count_next     = count_reg - CW'(1);
                                mem_rd_en      = 1'b1;
                                load_last_next = (count_reg != CW'(1));
                            end
                        end
                        CMD_REVERSE: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                rev_next = !rev_reg;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    state_next      = S_IDLE;
                    first_next      = first_eff;
                    last_next       = last_eff;
                    load_first_next = 1'b0;
                    load_last_next  = 1'b0;
                    out_valid_next  = 1'b1;
                    count_out_next  = ENTRY_W'(count_reg);
                    stat_out_next   = status_reg;
                    if (is_empty) begin
                        front_out_next = '0;
                        back_out_next  = '0;
                    end else begin
                        front_out_next = rev_reg ? last_eff : first_eff;
                        back_out_next  = rev_reg ? first_eff : last_eff;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            rev_reg        <= 1'b0;
            load_first_reg <= 1'b0;
            load_last_reg  <= 1'b0;
            status_reg     <= ST_OK;
            out_valid_reg  <= 1'b0;
            stat_out_reg   <= ST_OK;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            rev_reg        <= rev_next;
            load_first_reg <= load_first_next;
            load_last_reg  <= load_last_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            stat_out_reg   <= stat_out_next;
        end
        first_reg     <= first_next;
        last_reg      <= last_next;
        front_out_reg <= front_out_next;
        back_out_reg  <= back_out_next;
        count_out_reg <= count_out_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_front  = front_out_reg;
    assign m_back   = back_out_reg;
    assign m_count  = count_out_reg;
    assign m_status = stat_out_reg;

endmodule

/* hdl/double_ended_queue.sv */
// Top level of the bounded double-ended queue of 64-bit values.
`timescale 1ns / 1ps
// Usage:
//   Slave channel s_*: one request per beat carrying a command (push front,
//   push back, pop front, pop back, reverse, query) and a 64-bit value.
//   Master channel m_*: one result per request giving the front and back
//   values, the entry count and a status (ok, full, empty).
//   Each request passes through the accept state, which updates the pointers and
//   writes or reads the ring memory, and the result state, which takes the
//   registered read of that memory (the new end value after a pop) and loads
//   the result register. A new request is taken only after the previous one
//   has loaded the result register.
//   The result register parts the channels: a new request is taken while the
//   previous result still waits. If m_tready stays low, the next result is
//   held back and s_tready drops until the register frees.
//   Reset (aresetn low, synchronous) empties the queue, clears the direction
//   and drops any pending result; the ring memory itself is not cleared.
//   A push to a full queue is dropped; a pop or reverse on an empty queue
//   leaves it unchanged.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [2:0] cmd, [66:3] item_value, rest zero
    input  logic [dq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [63:0] front_value, [127:64] back_value, [136:128] entry_count,
    // [138:137] status, rest zero
    output logic [dq_pkg::M_TDATA_W-1:0] m_tdata
);
    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;
    logic [DATA_W-1:0] m_front;
    logic [DATA_W-1:0] m_back;
    logic [ENTRY_W-1:0] m_count;
    status_t           m_status;

    dq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_cmd       (cmd_t'(s_tdata[CMD_W-1:0])),
        .s_value     (s_tdata[CMD_W +: DATA_W]),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_front     (m_front),
        .m_back      (m_back),
        .m_count     (m_count),
        .m_status    (m_status)
    );

    dq_ring_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign m_tdata = M_TDATA_W'({m_status, m_count, m_back, m_front});

endmodule

/* hdl/dq_checker.sv */
// Port-level checks on the double-ended queue and their binding.
`timescale 1ns / 1ps
module dq_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [dq_pkg::M_TDATA_W-1:0] m_tdata
);
    import dq_pkg::*;

    logic [DATA_W-1:0]   front_value;
    logic [DATA_W-1:0]   back_value;
    logic [ENTRY_W-1:0]  entry_count;
    logic [STATUS_W-1:0] status;

    assign front_value = m_tdata[DATA_W-1:0];
    assign back_value  = m_tdata[2*DATA_W-1:DATA_W];
    assign entry_count = m_tdata[2*DATA_W+ENTRY_W-1:2*DATA_W];
    assign status      = m_tdata[M_FIELDS_W-1:2*DATA_W+ENTRY_W];

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> status == ST_OK || status == ST_FULL || status == ST_EMPTY)
        else $error("reserved status code");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && entry_count == '0 |-> front_value == '0 && back_value == '0)
        else $error("empty queue shows nonzero end values");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status == ST_EMPTY |-> entry_count == '0)
        else $error("empty status with stored entries");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for the double-ended queue: directed and random requests.
`timescale 1ns / 1ps
module tb;
    import dq_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;

    typedef struct packed {
        logic [DATA_W-1:0]  front_value;
        logic [DATA_W-1:0]  back_value;
        logic [ENTRY_W-1:0] entry_count;
        status_t            status;
    } deque_view_t;

    class deque_scoreboard;
        logic [DATA_W-1:0] ring [DEPTH];
        int unsigned       head;
        int unsigned       fill;
        bit                flipped;
        deque_view_t       views_due [$];
        int                errors;

        function new();
            head    = 0;
            fill    = 0;
            flipped = 0;
            errors  = 0;
        endfunction

        function int pending();
            return views_due.size();
        endfunction

        // advance the predicted deque by one accepted request
        function void note_request(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
            deque_view_t       want;
            bit                at_first;
            logic [DATA_W-1:0] first;
            logic [DATA_W-1:0] last;
            want.status = ST_OK;
            case (cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (fill >= DEPTH) begin
                        want.status = ST_FULL;
                    end else begin
                        at_first = (cmd == CMD_PUSH_FRONT) != flipped;
                        if (at_first) begin
                            head = (head + DEPTH - 1) % DEPTH;
                            ring[head] = value;
                        end else begin
                            ring[(head + fill) % DEPTH] = value;
                        end
                        fill++;
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK: begin
                    if (fill == 0) begin
                        want.status = ST_EMPTY;
                    end else begin
                        at_first = (cmd == CMD_POP_FRONT) != flipped;
                        if (at_first)
                            head = (head + 1) % DEPTH;
                        fill--;
                    end
                end
                CMD_REVERSE: begin
                    if (fill == 0)
                        want.status = ST_EMPTY;
                    else
                        flipped = !flipped;
                end
                default: ;
            endcase
            first = '0;
            last  = '0;
            if (fill != 0) begin
                first = ring[head];
                last  = ring[(head + fill - 1) % DEPTH];
            end
            want.front_value = flipped ? last : first;
            want.back_value  = flipped ? first : last;
            want.entry_count = fill[ENTRY_W-1:0];
            views_due.push_back(want);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            deque_view_t want;
            deque_view_t got;
            got.front_value = data[63:0];
            got.back_value  = data[127:64];
            got.entry_count = data[136:128];
            got.status      = status_t'(data[138:137]);
            if (views_due.size() == 0) begin
                $error("result with no request outstanding: %h", data);
                errors++;
                return;
            end
            want = views_due.pop_front();
            if (got.front_value !== want.front_value) begin
                $error("front_value: expected %h, actual %h", want.front_value, got.front_value);
                errors++;
            end
            if (got.back_value !== want.back_value) begin
                $error("back_value: expected %h, actual %h", want.back_value, got.back_value);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, actual %0d", want.entry_count,
                       got.entry_count);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int send_idle  = 0;
    int recv_stall = 0;

    deque_scoreboard sb = new();

    double_ended_queue #(.DEPTH(DEPTH)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, value, cmd};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, value);
    endtask

    // hold off new requests until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd(int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct)
            return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        if (r < push_pct + 8) begin
            case ($urandom_range(3))
                0:       return CMD_REVERSE;
                1:       return CMD_QUERY;
                default: return CMD_W'($urandom_range(7, 6));
            endcase
        end
        return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    endfunction

    initial begin
        int idle_pct  [4] = '{0, 67, 0, 34};
        int stall_pct [4] = '{0, 0, 67, 34};
        int push_pct  [4] = '{85, 10, 85, 10};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(CMD_QUERY, pick_value());
        send_request(CMD_POP_FRONT, pick_value());
        send_request(CMD_POP_BACK, pick_value());
        send_request(CMD_REVERSE, pick_value());
        send_request(CMD_PUSH_FRONT, '0);
        send_request(CMD_PUSH_BACK, '1);
        send_request(CMD_QUERY, '1);
        send_request(CMD_REVERSE, '0);
        send_request(CMD_POP_FRONT, '1);
        send_request(CMD_PUSH_FRONT, 64'h8000_0000_0000_0001);
        send_request(CMD_PUSH_BACK, 64'h7fff_ffff_ffff_fffe);
        send_request(CMD_REVERSE, '0);
        send_request(CMD_POP_BACK, '0);
        send_request(CMD_POP_BACK, '0);
        send_request(CMD_POP_BACK, '0);
        send_request(CMD_REVERSE, '0);
        send_request(CMD_W'(6), '1);
        send_request(CMD_W'(7), '1);
        send_request(CMD_PUSH_BACK, 64'h5555_5555_5555_5555);
        send_request(CMD_PUSH_FRONT, 64'haaaa_aaaa_aaaa_aaaa);
        send_request(CMD_W'(7), pick_value());
        send_request(CMD_POP_FRONT, '0);
        send_request(CMD_POP_FRONT, '0);
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = idle_pct[ph];
            recv_stall = stall_pct[ph];
            for (int n = 0; n < 432; n++)
                send_request(pick_cmd(push_pct[ph]), pick_value());
            drain_results();
        end

        send_idle  = 0;
        recv_stall = 0;
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
